// ----- sv/json_payload_object_locator_macros.svh -----
// Assertion macros shared by the locator RTL.
`ifndef JSON_PAYLOAD_OBJECT_LOCATOR_MACROS_SVH
`define JSON_PAYLOAD_OBJECT_LOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JPOL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JPOL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/jpol_pkg.sv -----
package jpol_pkg;

    localparam int MAX_LINE_BYTES = 4096;
    localparam int MAX_DEPTH      = 255;

    localparam int POS_W   = 13;
    localparam int START_W = 12;
    localparam int LEN_W   = 13;
    localparam int DEPTH_W = 8;
    localparam int KEY_W   = 4;

    localparam logic [KEY_W-1:0] KEY_LEN = 4'd9;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef struct packed {
        logic               fire;
        logic               found;
        logic [START_W-1:0] slice_start;
        logic [LEN_W-1:0]   slice_length;
    } t_result;

    // Characters of the quoted key, in order.
    function automatic logic [7:0] key_char(input logic [KEY_W-1:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = CH_QUOTE;
            4'd1:    c = 8'h70;
            4'd2:    c = 8'h61;
            4'd3:    c = 8'h79;
            4'd4:    c = 8'h6C;
            4'd5:    c = 8'h6F;
            4'd6:    c = 8'h61;
            4'd7:    c = 8'h64;
            4'd8:    c = CH_QUOTE;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};
    endfunction

endpackage

// ----- sv/jpol_scan.sv -----
module jpol_scan
    import jpol_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_line_byte,
    input  logic       i_line_end,
    output t_result    o_res
);

    typedef enum logic [4:0] {
        PH_SEARCH = 5'b00001,
        PH_COLON  = 5'b00010,
        PH_BRACE  = 5'b00100,
        PH_BODY   = 5'b01000,
        PH_DONE   = 5'b10000
    } t_phase;

    localparam logic [POS_W-1:0]   POS_LIMIT   = POS_W'(MAX_LINE_BYTES);
    localparam logic [DEPTH_W-1:0] DEPTH_LIMIT = DEPTH_W'(MAX_DEPTH);

    t_phase             r_phase,  n_phase;
    logic [KEY_W-1:0]   r_key,    n_key;
    logic [POS_W-1:0]   r_pos,    n_pos;
    logic [START_W-1:0] r_start,  n_start;
    logic [DEPTH_W-1:0] r_depth,  n_depth;
    logic               r_in_str, n_in_str;
    logic               r_esc,    n_esc;

    logic [DEPTH_W-1:0] depth_dec;
    t_result            res;

    always_comb begin
        n_phase  = r_phase;
        n_key    = r_key;
        n_pos    = r_pos;
        n_start  = r_start;
        n_depth  = r_depth;
        n_in_str = r_in_str;
        n_esc    = r_esc;
        res      = '0;
        depth_dec = (r_depth != '0) ? r_depth - 1'b1 : '0;

        if (r_phase != PH_DONE) begin
            if (r_pos >= POS_LIMIT) begin
                res.fire = 1'b1;
                n_phase  = PH_DONE;
            end else begin
                case (r_phase)
                    PH_SEARCH: begin
                        if (r_key < KEY_LEN && i_line_byte == key_char(r_key)) begin
                            n_key = r_key + 1'b1;
                        end else begin
                            n_key = (i_line_byte == CH_QUOTE) ? KEY_W'(1) : '0;
                        end
                        if (n_key >= KEY_LEN) begin
                            n_phase = PH_COLON;
                        end
                    end
                    PH_COLON: begin
                        if (i_line_byte == CH_COLON) begin
                            n_phase = PH_BRACE;
                        end else if (!is_blank(i_line_byte)) begin
                            res.fire = 1'b1;
                            n_phase  = PH_DONE;
                        end
                    end
                    PH_BRACE: begin
                        if (i_line_byte == CH_LBRACE) begin
                            n_start  = r_pos[START_W-1:0];
                            n_depth  = DEPTH_W'(1);
                            n_in_str = 1'b0;
                            n_esc    = 1'b0;
                            n_phase  = PH_BODY;
                        end else if (!is_blank(i_line_byte)) begin
                            res.fire = 1'b1;
                            n_phase  = PH_DONE;
                        end
                    end
                    PH_BODY: begin
                        if (r_esc) begin
                            n_esc = 1'b0;
                        end else if (r_in_str) begin
                            if (i_line_byte == CH_BSLASH) begin
                                n_esc = 1'b1;
                            end else if (i_line_byte == CH_QUOTE) begin
                                n_in_str = 1'b0;
                            end
                        end else if (i_line_byte == CH_QUOTE) begin
                            n_in_str = 1'b1;
                        end else if (i_line_byte == CH_LBRACE) begin
                            if (r_depth >= DEPTH_LIMIT) begin
                                res.fire = 1'b1;
                                n_phase  = PH_DONE;
                            end else begin
                                n_depth = r_depth + 1'b1;
                            end
                        end else if (i_line_byte == CH_RBRACE) begin
                            n_depth = depth_dec;
                            if (depth_dec == '0) begin
                                res.fire         = 1'b1;
                                res.found        = 1'b1;
                                res.slice_start  = r_start;
                                res.slice_length = LEN_W'(r_pos - {1'b0, r_start}) + 1'b1;
                                n_phase          = PH_DONE;
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_DONE;
                    end
                endcase
            end
        end

        if (r_pos < POS_LIMIT) begin
            n_pos = r_pos + 1'b1;
        end

        if (i_line_end) begin
            if (!res.fire && n_phase != PH_DONE) begin
                res.fire = 1'b1;
            end
            n_phase  = PH_SEARCH;
            n_key    = '0;
            n_pos    = '0;
            n_start  = '0;
            n_depth  = '0;
            n_in_str = 1'b0;
            n_esc    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SEARCH;
            r_key    <= '0;
            r_pos    <= '0;
            r_start  <= '0;
            r_depth  <= '0;
            r_in_str <= 1'b0;
            r_esc    <= 1'b0;
        end else if (i_take) begin
            r_phase  <= n_phase;
            r_key    <= n_key;
            r_pos    <= n_pos;
            r_start  <= n_start;
            r_depth  <= n_depth;
            r_in_str <= n_in_str;
            r_esc    <= n_esc;
        end
    end

    assign o_res = res;

endmodule

// ----- sv/json_payload_object_locator.sv -----
// Scans a text line one byte per transfer and reports, once per line, where the object
// value of the first quoted "payload" key lies: the offset of its opening brace and its
// length through the matching closing brace, or not found. The block takes one byte in
// every cycle in which input ready is high; the result of a byte is offered on the output
// in the cycle after that byte's transfer, from a single output register. Input ready
// drops only while that register holds a result that the output side has not taken.
`include "json_payload_object_locator_macros.svh"

module json_payload_object_locator
    import jpol_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_line_byte,
    input  logic               i_line_end,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_found,
    output logic [START_W-1:0] o_slice_start,
    output logic [LEN_W-1:0]   o_slice_length
);

    logic               take;
    t_result            res;
    logic               r_valid, n_valid;
    logic               r_found;
    logic [START_W-1:0] r_start;
    logic [LEN_W-1:0]   r_length;

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;

    jpol_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_line_byte (i_line_byte),
        .i_line_end  (i_line_end),
        .o_res       (res)
    );

    always_comb begin
        n_valid = r_valid;
        if (take && res.fire) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && res.fire) begin
            r_found  <= res.found;
            r_start  <= res.slice_start;
            r_length <= res.slice_length;
        end
    end

    assign o_valid        = r_valid;
    assign o_found        = r_found;
    assign o_slice_start  = r_start;
    assign o_slice_length = r_length;

    `JPOL_ASSERT_SAME(a_found_has_length, i_clk, i_rst_n, o_valid && o_found, o_slice_length != '0 && o_slice_length <= LEN_W'(MAX_LINE_BYTES), "located object has a bad length")
    `JPOL_ASSERT_SAME(a_miss_is_zero, i_clk, i_rst_n, o_valid && !o_found, o_slice_start == '0 && o_slice_length == '0, "not-found result carries a nonzero slice")
    `JPOL_ASSERT_SAME(a_result_from_transfer, i_clk, i_rst_n, $rose(o_valid), $past(i_valid && o_ready), "result appeared without an input transfer")

endmodule
